// ----- hdl/alpe_pkg.sv -----
// Package for the alarm list unit: sizes, entry and response structs, FSM states.
// Used by alpe_seq and the top level; has no dependencies.
package alpe_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int TYPE_BITS   = 8;
    localparam int CAP_W       = 5;
    localparam int CAP_RESET   = 16;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int ENTRY_W    = TYPE_BITS + 2;
    localparam int S_FIELDS_W = TYPE_BITS + 3;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 + TYPE_BITS + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // request kinds carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // response status codes
    localparam logic STAT_DONE  = 1'b0;
    localparam logic STAT_ERROR = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [TYPE_BITS-1:0] alarm_type;
        logic                 is_normal;
        logic                 notify_on_add;
        logic                 notify_on_remove;
    } req_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0] etype;
        logic                 normal;
        logic                 notify;
    } entry_t;

    typedef struct packed {
        logic                 status;
        logic                 added_notify;
        logic                 removed_notify;
        logic [TYPE_BITS-1:0] removed_type;
        logic [CNT_W-1:0]     entry_count;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

// ----- hdl/alpe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; read data is registered.
module alpe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/alpe_seq.sv -----
// Request sequencer: scans the entry RAM, compacts it after a removal, appends.
// Depends on alpe_pkg and alpe_ram.
module alpe_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    output logic                   in_ready,
    input  alpe_pkg::req_t         req,
    input  logic [alpe_pkg::CAP_W-1:0] cap,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output alpe_pkg::rsp_t         rsp
);

    alpe_pkg::state_t state_reg, state_next;
    alpe_pkg::req_t   req_reg, req_next;

    logic [alpe_pkg::CNT_W-1:0] count_reg, count_next;
    logic [alpe_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [alpe_pkg::CNT_W-1:0] rdpos_reg, rdpos_next;
    logic                       rd_valid_reg, rd_valid_next;

    logic                           status_reg, status_next;
    logic                           added_reg, added_next;
    logic                           rnotify_reg, rnotify_next;
    logic [alpe_pkg::TYPE_BITS-1:0] rtype_reg, rtype_next;

    logic                       rd_en;
    logic [alpe_pkg::IDX_W-1:0] rd_addr;
    alpe_pkg::entry_t           rd_data;
    logic                       wr_en;
    logic [alpe_pkg::IDX_W-1:0] wr_addr;
    alpe_pkg::entry_t           wr_data;

    logic                       full;
    logic                       issue;
    logic                       hit;
    logic [alpe_pkg::CNT_W-1:0] rdpos_dec;

    alpe_ram #(
        .DATA_W (alpe_pkg::ENTRY_W),
        .DEPTH  (alpe_pkg::MAX_ENTRIES),
        .ADDR_W (alpe_pkg::IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // full when count reaches capacity or the store depth
    assign full = (alpe_pkg::CMP_W'(count_reg) >= alpe_pkg::CMP_W'(cap)) ||
                  (count_reg >= alpe_pkg::CNT_W'(alpe_pkg::MAX_ENTRIES));
    assign issue     = (ptr_reg < count_reg);
    assign hit       = (req_reg.req_type == alpe_pkg::REQ_REMOVE) ?
                       (rd_data.etype == req_reg.alarm_type) : rd_data.normal;
    assign rdpos_dec = rdpos_reg - alpe_pkg::CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        rdpos_next    = rdpos_reg;
        rd_valid_next = rd_valid_reg;
        status_next   = status_reg;
        added_next    = added_reg;
        rnotify_next  = rnotify_reg;
        rtype_next    = rtype_reg;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[alpe_pkg::IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = rdpos_dec[alpe_pkg::IDX_W-1:0];
        wr_data       = rd_data;
        in_ready      = 1'b0;

        case (state_reg)
            alpe_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (start) begin
                    req_next      = req;
                    ptr_next      = '0;
                    rd_valid_next = 1'b0;
                    status_next   = alpe_pkg::STAT_DONE;
                    added_next    = 1'b0;
                    rnotify_next  = 1'b0;
                    rtype_next    = '0;
                    if (req.req_type == alpe_pkg::REQ_INSERT && !full) begin
                        state_next = alpe_pkg::ST_APPEND;
                    end else if (count_reg == '0) begin
                        status_next = alpe_pkg::STAT_ERROR;
                        state_next  = alpe_pkg::ST_RESP;
                    end else begin
                        state_next = alpe_pkg::ST_SCAN;
                    end
                end
            end
            alpe_pkg::ST_SCAN: begin
                // issue the next read while checking the previous one
                if (issue) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rdpos_next    = ptr_reg;
                    ptr_next      = ptr_reg + alpe_pkg::CNT_W'(1);
                end else begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg && hit) begin
                    rd_en         = 1'b0;
                    rd_valid_next = 1'b0;
                    rtype_next    = rd_data.etype;
                    rnotify_next  = rd_data.notify;
                    ptr_next      = rdpos_reg + alpe_pkg::CNT_W'(1);
                    state_next    = alpe_pkg::ST_SHIFT;
                end else if (!issue) begin
                    status_next = alpe_pkg::STAT_ERROR;
                    state_next  = alpe_pkg::ST_RESP;
                end
            end
            alpe_pkg::ST_SHIFT: begin
                // move each younger entry up by one slot
                if (issue) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    rdpos_next    = ptr_reg;
                    ptr_next      = ptr_reg + alpe_pkg::CNT_W'(1);
                end else begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg) begin
                    wr_en = 1'b1;
                end
                if (!issue && !rd_valid_reg) begin
                    count_next = count_reg - alpe_pkg::CNT_W'(1);
                    state_next = (req_reg.req_type == alpe_pkg::REQ_REMOVE) ?
                                 alpe_pkg::ST_RESP : alpe_pkg::ST_APPEND;
                end
            end
            alpe_pkg::ST_APPEND: begin
                wr_en          = 1'b1;
                wr_addr        = count_reg[alpe_pkg::IDX_W-1:0];
                wr_data.etype  = req_reg.alarm_type;
                wr_data.normal = req_reg.is_normal;
                wr_data.notify = req_reg.notify_on_remove;
                count_next     = count_reg + alpe_pkg::CNT_W'(1);
                added_next     = req_reg.notify_on_add;
                state_next     = alpe_pkg::ST_RESP;
            end
            alpe_pkg::ST_RESP: begin
                if (rsp_ready) begin
                    state_next = alpe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = alpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= alpe_pkg::ST_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        ptr_reg     <= ptr_next;
        rdpos_reg   <= rdpos_next;
        status_reg  <= status_next;
        added_reg   <= added_next;
        rnotify_reg <= rnotify_next;
        rtype_reg   <= rtype_next;
    end

    assign rsp_valid           = (state_reg == alpe_pkg::ST_RESP);
    assign rsp.status          = status_reg;
    assign rsp.added_notify    = added_reg;
    assign rsp.removed_notify  = rnotify_reg;
    assign rsp.removed_type    = rtype_reg;
    assign rsp.entry_count     = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= alpe_pkg::CNT_W'(alpe_pkg::MAX_ENTRIES))
        else $error("entry count above store depth");

    a_append_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == alpe_pkg::ST_APPEND |=>
        count_reg == $past(count_reg) + alpe_pkg::CNT_W'(1))
        else $error("append did not advance the count");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == alpe_pkg::ST_SHIFT || state_reg == alpe_pkg::ST_APPEND))
        else $error("entry RAM written outside shift or append");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && status_reg == alpe_pkg::STAT_ERROR |->
        !added_reg && !rnotify_reg && rtype_reg == '0)
        else $error("failed request reports a change");

endmodule

// ----- hdl/alarm_list_with_priority_eviction_unit.sv -----
// Top level of the alarm list unit: stream ports, capacity register, result register.
// Depends on alpe_pkg, alpe_seq and alpe_ram.
//
// Holds up to MAX_ENTRIES alarms oldest first in a single entry RAM (one write
// port, one registered read port). An insert (s_tuser = 0) appends at the tail;
// when the list is at capacity the oldest normal entry is evicted and reported
// first, and with no normal entry the insert fails with status 1. A remove
// (s_tuser = 1) deletes the oldest entry of the given type. Each request gives
// exactly one result transaction. One request is in work at a time. An insert
// that needs no eviction goes through the append state to the result register,
// and a remove on an empty list fails with status 1 without a search. A search
// walks the RAM one entry per cycle behind the registered read, and the
// compaction after a hit moves each younger entry up one slot per cycle, so the
// time for a removal, an eviction with its append, or a search that finds
// nothing grows with the entries held, all set by the single read port of the
// entry RAM. A result may also wait for m_tready to free the result register.
// The next request is taken while a result still waits on m_tready. Entries
// need no clearing after reset, so requests are taken from the first cycle.
// Write cfg_wr_data (capacity, 1..16, reset 16; above 16 acts as 16) only while
// the unit is idle.
module alarm_list_with_priority_eviction_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // alarm_type, is_normal, notify_on_add, notify_on_remove, zero pad
    input  logic [alpe_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, added_notify, removed_notify, removed_type, entry_count
    output logic [alpe_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [alpe_pkg::CAP_W-1:0]     cfg_wr_data
);

    logic [alpe_pkg::CAP_W-1:0]     cap_reg, cap_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [alpe_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    alpe_pkg::req_t req;
    alpe_pkg::rsp_t rsp;
    logic           start;
    logic           in_ready;
    logic           rsp_valid;
    logic           out_free;
    logic           load;

    // unpack the input transaction, lowest field first
    assign req.req_type         = s_tuser;
    assign req.alarm_type       = s_tdata[alpe_pkg::TYPE_BITS-1:0];
    assign req.is_normal        = s_tdata[alpe_pkg::TYPE_BITS];
    assign req.notify_on_add    = s_tdata[alpe_pkg::TYPE_BITS+1];
    assign req.notify_on_remove = s_tdata[alpe_pkg::TYPE_BITS+2];

    assign s_tready = in_ready;
    assign start    = s_tvalid && in_ready;

    // the result register frees itself in the same cycle it is taken
    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = rsp_valid && out_free;

    alpe_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .in_ready  (in_ready),
        .req       (req),
        .cap       (cap_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (out_free),
        .rsp       (rsp)
    );

    always_comb begin
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load) begin
            // pack fields from the lowest bit up
            m_tvalid_next = 1'b1;
            m_tdata_next  = alpe_pkg::M_TDATA_W'({rsp.entry_count, rsp.removed_type,
                                                  rsp.removed_notify, rsp.added_notify,
                                                  rsp.status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= alpe_pkg::CAP_W'(alpe_pkg::CAP_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("result transaction lost before it was taken");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid |-> !in_ready)
        else $error("request accepted while a result is pending");

    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> !rsp_valid)
        else $error("same result loaded twice");

endmodule
